// ===== rtl/core/tcr_pkg.sv =====
`default_nettype none
package tcr_pkg;
    localparam int MaxNodes = 64;
    localparam int MaxEdges = 128;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int EdgeW = $clog2(MaxEdges);

    localparam logic [2:0] OP_LOAD_EDGE = 3'd0;
    localparam logic [2:0] OP_LOAD_NODE = 3'd1;
    localparam logic [2:0] OP_BUILD     = 3'd2;
    localparam logic [2:0] OP_FETCH     = 3'd3;
    localparam logic [2:0] OP_XLATE     = 3'd4;

    localparam logic [2:0] KIND_DENSE = 3'd0;
    localparam logic [2:0] KIND_EDGE  = 3'd1;
    localparam logic [2:0] KIND_O2D   = 3'd2;
    localparam logic [2:0] KIND_XLATE = 3'd3;
    localparam logic [2:0] KIND_NONE  = 3'd4;

    localparam logic [0:0] REG_THRESHOLD = 1'd0;
    localparam logic [0:0] REG_FILTER_ON = 1'd1;

    typedef struct packed {
        logic [NodeW-1:0] a;
        logic [NodeW-1:0] b;
        logic [15:0]      fid;
        logic             present;
    } t_edge;
endpackage
`default_nettype wire

// ===== rtl/core/topology_compact_and_remap_top.sv =====
`default_nettype none
// A request is taken at a clock edge where start is high and busy is low. Loads and builds
// give no result. Each fetch or translate gives exactly one result, shown with o_strobe for
// a single cycle; the receiver cannot stall it. A load does not raise busy. A translate
// holds busy through S_XLATE. A fetch holds busy through S_F_DENSE and S_F_DENSE2 on a
// dense entry, through S_F_EDGE, S_F_EDGE2 and S_F_O2D on a kept edge (slot, edge and remap
// reads in turn) and through S_F_O2D alone on an original-to-dense entry. Past the end of
// the stream a fetch does not raise busy. o_strobe rises in the cycle in which busy falls,
// or in the cycle right after the request when busy stays low. A build holds busy through
// an edge pass (S_B_EDGE, S_B_EDGE_W per loaded edge, ending in S_B_EDGE), a node pass that
// marks by fidelity (S_B_NODE, S_B_NODE_W) and a rank pass (S_B_RANK, S_B_RANK_W), all
// stepping the one index r_idx. A per-node written flag makes node fidelities that were
// never loaded read as zero, so reset needs no clearing pass.
module topology_compact_and_remap_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_op,
    input  wire logic [5:0]  i_node_a,
    input  wire logic [5:0]  i_node_b,
    input  wire logic [15:0] i_fidelity,
    input  wire logic        i_fidelity_present,
    input  wire logic [7:0]  i_query_id,
    output logic             o_strobe,
    output logic [2:0]       o_result_kind,
    output logic [6:0]       o_position,
    output logic [7:0]       o_id_a,
    output logic [5:0]       o_id_b,
    output logic [15:0]      o_fidelity_out,
    output logic             o_entry_valid,
    output logic [6:0]       o_dense_total,
    output logic             o_last
);
    localparam int NW = tcr_pkg::NodeW;
    localparam int EW = tcr_pkg::EdgeW;

    typedef enum logic [3:0] {
        S_IDLE, S_B_EDGE, S_B_EDGE_W, S_B_NODE, S_B_NODE_W, S_B_RANK, S_B_RANK_W,
        S_F_DENSE, S_F_DENSE2, S_F_EDGE, S_F_EDGE2, S_F_O2D, S_XLATE
    } t_state;

    // Memories.
    tcr_pkg::t_edge    edge_mem [tcr_pkg::MaxEdges];
    logic [15:0]       nfid_mem [tcr_pkg::MaxNodes];
    logic [NW-1:0]     d2o_mem  [tcr_pkg::MaxNodes];
    logic [NW-1:0]     o2d_mem  [tcr_pkg::MaxNodes];
    logic [EW-1:0]     kslot_mem[tcr_pkg::MaxEdges];

    logic [tcr_pkg::MaxNodes-1:0] r_marked;
    logic [tcr_pkg::MaxNodes-1:0] r_nfid_set;
    logic [15:0]       r_threshold;
    logic              r_filter_on;
    t_state            r_state;
    logic [EW:0]       r_edge_count;
    logic [EW:0]       r_kept_count;
    logic [NW:0]       r_dense_count;
    logic [NW-1:0]     r_highest;
    logic [EW+NW+1:0]  r_fptr;
    logic [EW:0]       r_idx;
    logic              r_built;
    logic [7:0]        r_query;

    tcr_pkg::t_edge    r_edge_rd;
    logic [15:0]       r_nfid_rd;
    logic              r_nfid_ok;
    logic [NW-1:0]     r_d2o_rd;
    logic [NW-1:0]     r_o2d_rd_a;
    logic [NW-1:0]     r_o2d_rd_b;
    logic [EW-1:0]     r_kslot_rd;
    logic [6:0]        r_pos;
    logic              r_last;

    logic [EW+NW+1:0]  n0, n1, n2, total;
    logic              filter, edge_keep;
    logic [15:0]       efid;
    logic [15:0]       nfid_rd;
    logic [NW-1:0]     nfid_addr;

    assign filter = r_filter_on && (r_threshold != 16'd0);
    assign efid = r_edge_rd.present ? r_edge_rd.fid : 16'd0;
    assign edge_keep = !filter || (efid > r_threshold);
    assign busy = (r_state != S_IDLE);
    assign nfid_rd = r_nfid_ok ? r_nfid_rd : 16'd0;
    assign nfid_addr = (r_state == S_F_DENSE) ? r_d2o_rd : r_idx[NW-1:0];

    always_comb begin
        n0 = (EW+NW+2)'(r_dense_count);
        n1 = (EW+NW+2)'(r_kept_count);
        n2 = (r_dense_count != '0) ? (EW+NW+2)'(r_highest) + 1'b1 : '0;
        total = n0 + n1 + n2;
    end

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start && i_op == tcr_pkg::OP_LOAD_EDGE
                && r_edge_count < (EW+1)'(tcr_pkg::MaxEdges))
            edge_mem[r_edge_count[EW-1:0]] <= '{a: i_node_a, b: i_node_b,
                fid: i_fidelity, present: i_fidelity_present};
        if (r_state == S_IDLE && start && i_op == tcr_pkg::OP_LOAD_NODE)
            nfid_mem[i_node_a] <= i_fidelity;
        if (r_state == S_B_EDGE_W && edge_keep)
            kslot_mem[r_kept_count[EW-1:0]] <= r_idx[EW-1:0] - 1'b1;
        if (r_state == S_B_RANK && r_marked[r_idx[NW-1:0]]) begin
            d2o_mem[r_dense_count[NW-1:0]] <= r_idx[NW-1:0];
            o2d_mem[r_idx[NW-1:0]] <= r_dense_count[NW-1:0];
        end
        // The kept-edge fetch holds its edge address until the result is out.
        r_edge_rd  <= edge_mem[(r_state == S_F_EDGE || r_state == S_F_EDGE2) ? r_kslot_rd
                                                                           : r_idx[EW-1:0]];
        r_nfid_rd  <= nfid_mem[nfid_addr];
        r_nfid_ok  <= r_nfid_set[nfid_addr];
        r_d2o_rd   <= d2o_mem[(r_state == S_IDLE && i_op == tcr_pkg::OP_XLATE)
                              ? i_query_id[NW-1:0] : r_fptr[NW-1:0]];
        r_kslot_rd <= kslot_mem[EW'(r_fptr - n0)];
        r_o2d_rd_a <= o2d_mem[(r_state == S_F_EDGE2) ? r_edge_rd.a
                                                     : NW'(r_fptr - n0 - n1)];
        r_o2d_rd_b <= o2d_mem[r_edge_rd.b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0; r_filter_on <= 1'b0; r_state <= S_IDLE;
            r_edge_count <= '0; r_kept_count <= '0; r_dense_count <= '0;
            r_highest <= '0; r_fptr <= '0; r_idx <= '0; r_marked <= '0;
            r_nfid_set <= '0; r_query <= '0;
            r_built <= 1'b0; o_strobe <= 1'b0;
            o_result_kind <= '0; o_position <= '0; o_id_a <= '0; o_id_b <= '0;
            o_fidelity_out <= '0; o_entry_valid <= 1'b0; o_last <= 1'b0;
            r_pos <= '0; r_last <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == tcr_pkg::REG_THRESHOLD) r_threshold <= i_cfg_data;
                else r_filter_on <= i_cfg_data[0];
            end
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (start) begin
                        case (i_op)
                            tcr_pkg::OP_LOAD_EDGE:
                                if (r_edge_count < (EW+1)'(tcr_pkg::MaxEdges))
                                    r_edge_count <= r_edge_count + 1'b1;
                            tcr_pkg::OP_LOAD_NODE: r_nfid_set[i_node_a] <= 1'b1;
                            tcr_pkg::OP_BUILD: begin
                                r_marked <= '0; r_kept_count <= '0;
                                r_dense_count <= '0; r_highest <= '0;
                                r_fptr <= '0; r_built <= 1'b1;
                                r_state <= S_B_EDGE;
                            end
                            tcr_pkg::OP_FETCH: begin
                                r_last <= (r_fptr + 1'b1 == total);
                                if (!r_built || r_fptr >= total) begin
                                    o_strobe <= 1'b1;
                                    o_result_kind <= tcr_pkg::KIND_NONE;
                                    o_position <= '0; o_id_a <= '0; o_id_b <= '0;
                                    o_fidelity_out <= '0; o_entry_valid <= 1'b0;
                                    o_last <= 1'b1;
                                end else if (r_fptr < n0) begin
                                    r_state <= S_F_DENSE;
                                end else if (r_fptr < n0 + n1) begin
                                    r_state <= S_F_EDGE;
                                end else begin
                                    r_state <= S_F_O2D;
                                end
                            end
                            tcr_pkg::OP_XLATE: begin
                                r_query <= i_query_id;
                                r_state <= S_XLATE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_B_EDGE: begin
                    // Address cycle for edge r_idx.
                    if (r_idx >= r_edge_count) begin
                        r_idx <= '0;
                        r_state <= S_B_NODE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_B_EDGE_W;
                    end
                end
                S_B_EDGE_W: begin
                    if (edge_keep) begin
                        r_kept_count <= r_kept_count + 1'b1;
                        r_marked[r_edge_rd.a] <= 1'b1;
                        r_marked[r_edge_rd.b] <= 1'b1;
                    end
                    r_state <= S_B_EDGE;
                end
                S_B_NODE: r_state <= S_B_NODE_W;
                S_B_NODE_W: begin
                    if (r_threshold != 16'd0 && nfid_rd > r_threshold)
                        r_marked[r_idx[NW-1:0]] <= 1'b1;
                    if (r_idx == (EW+1)'(tcr_pkg::MaxNodes - 1)) begin
                        r_idx <= '0;
                        r_state <= S_B_RANK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_B_NODE;
                    end
                end
                S_B_RANK: begin
                    if (r_marked[r_idx[NW-1:0]]) begin
                        r_dense_count <= r_dense_count + 1'b1;
                        r_highest <= r_idx[NW-1:0];
                    end
                    r_state <= S_B_RANK_W;
                end
                S_B_RANK_W: begin
                    if (r_idx == (EW+1)'(tcr_pkg::MaxNodes - 1)) begin
                        if (r_dense_count == '0) r_kept_count <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_B_RANK;
                    end
                end
                S_F_DENSE: r_state <= S_F_DENSE2;
                S_F_DENSE2: begin
                    o_strobe <= 1'b1; o_result_kind <= tcr_pkg::KIND_DENSE;
                    o_position <= 7'(r_fptr); o_id_a <= 8'(r_d2o_rd); o_id_b <= '0;
                    o_fidelity_out <= nfid_rd; o_entry_valid <= 1'b0;
                    o_last <= r_last; r_fptr <= r_fptr + 1'b1; r_state <= S_IDLE;
                end
                S_F_EDGE: r_state <= S_F_EDGE2;
                S_F_EDGE2: begin
                    r_pos <= 7'(r_fptr - n0);
                    r_state <= S_F_O2D;
                end
                S_F_O2D: begin
                    // Shared finish for kept edges and original-to-dense entries.
                    o_strobe <= 1'b1; o_last <= r_last; r_fptr <= r_fptr + 1'b1;
                    r_state <= S_IDLE;
                    if (r_fptr < n0 + n1) begin
                        o_result_kind <= tcr_pkg::KIND_EDGE; o_position <= r_pos;
                        o_id_a <= 8'(r_o2d_rd_a); o_id_b <= r_o2d_rd_b;
                        o_fidelity_out <= r_edge_rd.present ? r_edge_rd.fid : 16'd0;
                        o_entry_valid <= 1'b0;
                    end else begin
                        o_result_kind <= tcr_pkg::KIND_O2D;
                        o_position <= 7'(r_fptr - n0 - n1);
                        o_id_a <= r_marked[NW'(r_fptr - n0 - n1)] ? 8'(r_o2d_rd_a) : 8'd0;
                        o_id_b <= '0; o_fidelity_out <= '0;
                        o_entry_valid <= r_marked[NW'(r_fptr - n0 - n1)];
                    end
                end
                S_XLATE: begin
                    o_strobe <= 1'b1; o_result_kind <= tcr_pkg::KIND_XLATE;
                    o_position <= '0; o_id_b <= '0; o_fidelity_out <= '0;
                    o_last <= 1'b0;
                    r_state <= S_IDLE;
                    if (9'(r_query) < 9'(r_dense_count)) begin
                        o_id_a <= 8'(r_d2o_rd); o_entry_valid <= 1'b1;
                    end else begin
                        o_id_a <= r_query; o_entry_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_dense_total = 7'(r_dense_count);

    a_dense_le_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dense_count <= (NW+1)'(tcr_pkg::MaxNodes))
        else $error("dense count overflow");
    a_kept_le_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_count <= r_edge_count)
        else $error("kept count exceeds loaded edges");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !$past(busy) || $past(r_state) == S_F_DENSE2
            || $past(r_state) == S_F_O2D || $past(r_state) == S_XLATE)
        else $error("result outside a fetch or translate");
endmodule
`default_nettype wire
